[rtl/msalu_pkg.sv]
// ----------------------------------------------------------------------------
// msalu_pkg: shared types and constants for the masked SIMD integer ALU
// Opcodes, word formats, lane pipeline stage record and depth constants.
// ----------------------------------------------------------------------------
package msalu_pkg;

    localparam int MAX_LANES  = 2;
    localparam int LANE_W     = 32;
    localparam int DIV_STEPS  = LANE_W;

    localparam logic [3:0] OP_SET   = 4'd0;
    localparam logic [3:0] OP_MOVE  = 4'd1;
    localparam logic [3:0] OP_ADD   = 4'd2;
    localparam logic [3:0] OP_SUB   = 4'd3;
    localparam logic [3:0] OP_MUL   = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_ABS   = 4'd6;
    localparam logic [3:0] OP_GT    = 4'd7;
    localparam logic [3:0] OP_LT    = 4'd8;
    localparam logic [3:0] OP_EQ    = 4'd9;
    localparam logic [3:0] OP_NOT   = 4'd10;
    localparam logic [3:0] OP_OR    = 4'd11;
    localparam logic [3:0] OP_AND   = 4'd12;
    localparam logic [3:0] OP_COUNT = 4'd13;
    localparam logic [3:0] OP_FIRST = 4'd14;

    typedef struct packed {
        logic [3:0]         op;
        logic [63:0]        vec_a;
        logic [63:0]        vec_b;
        logic signed [31:0] scalar;
        logic [1:0]         lane_mask;
        logic [63:0]        old_vec;
        logic [1:0]         old_mask;
    } cmd_t;

    typedef struct packed {
        logic [63:0] result_vec;
        logic [1:0]  result_mask;
        logic [1:0]  bit_count;
    } rsp_t;

    // One stage of a lane: divider state plus the already finished result.
    typedef struct packed {
        logic [LANE_W-1:0] rem;
        logic [LANE_W-1:0] dq;
        logic [LANE_W-1:0] dvs;
        logic              neg;
        logic              dz;
        logic              div;
        logic [LANE_W-1:0] res;
        logic              cmp;
    } lane_stage_t;

    // Control that travels beside the lanes to the merge stage.
    typedef struct packed {
        logic [3:0] op;
        logic [1:0] lane_mask;
        logic [1:0] old_mask;
        logic [1:0] first_ones;
    } ctl_t;

endpackage

[rtl/masked_simd_integer_alu_unit.sv]
// ----------------------------------------------------------------------------
// masked_simd_integer_alu_unit: masked two-lane integer SIMD ALU
// Lane ops with per-lane enables, pipelined divide, and mask logic.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid, cmd_stall, cmd_word) takes one instruction word:
//   opcode, two packed vectors, scalar, lane mask, old vector and old mask.
//   rsp channel (rsp_valid, rsp_stall, rsp_word) returns one result word per
//   instruction, in order.
//   From accept to rsp_valid a word passes one setup stage, 32 divider
//   stages (one quotient bit each) and the output register. Every
//   op travels the same path, so results never reorder.
//   Throughput is one word per cycle unless rsp_stall holds a result; each
//   lane's restoring divider is fully pipelined and sets the depth.
//   When rsp_stall holds a valid result, the whole pipe freezes and
//   cmd_stall rises in the same cycle; bubbles do not collapse.
//   Reset clears all valid bits; payload registers are not reset.
//   LANES (1 or 2) selects how many lanes act; an unused lane keeps
//   old_vec and old_mask and is not counted.
// ----------------------------------------------------------------------------
module masked_simd_integer_alu_unit #(
    parameter int LANES = msalu_pkg::MAX_LANES
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  msalu_pkg::cmd_t cmd_word,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output msalu_pkg::rsp_t rsp_word
);

    localparam int L     = msalu_pkg::MAX_LANES;
    localparam int W     = msalu_pkg::LANE_W;
    localparam int DEPTH = msalu_pkg::DIV_STEPS + 1;

    logic                   advance;
    logic [L-1:0]           active;
    logic [L-1:0]           cmp;
    logic [L*W-1:0]         words;
    msalu_pkg::ctl_t        ctl_next;
    msalu_pkg::ctl_t        ctl_reg [0:DEPTH-1];
    logic [DEPTH-1:0]       vld_reg;
    msalu_pkg::rsp_t        merged;
    msalu_pkg::rsp_t        rsp_reg;
    logic                   rsp_vld_reg;

    // Freeze everything while a finished word waits at the output.
    assign advance   = !(rsp_vld_reg && rsp_stall);
    assign cmd_stall = !advance;

    always_comb
    begin
        for (int i = 0; i < L; i++)
            active[i] = (i < LANES);
        ctl_next.op         = cmd_word.op;
        ctl_next.lane_mask  = cmd_word.lane_mask;
        ctl_next.old_mask   = cmd_word.old_mask;
        ctl_next.first_ones = {cmd_word.scalar > 32'sd1, cmd_word.scalar > 32'sd0};
    end

    for (genvar g = 0; g < L; g++)
    begin : g_lane
        msalu_lane u_lane (
            .clk     (clk),
            .advance (advance),
            .en      (active[g] & cmd_word.lane_mask[g]),
            .op      (cmd_word.op),
            .a       (cmd_word.vec_a[g*W +: W]),
            .b       (cmd_word.vec_b[g*W +: W]),
            .scalar  (cmd_word.scalar),
            .old     (cmd_word.old_vec[g*W +: W]),
            .word    (words[g*W +: W]),
            .cmp     (cmp[g])
        );
    end

    // Control rides beside the lanes.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctl_reg[0] <= ctl_next;
            for (int k = 1; k < DEPTH; k++)
                ctl_reg[k] <= ctl_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg     <= {vld_reg[DEPTH-2:0], cmd_valid};
            rsp_vld_reg <= vld_reg[DEPTH-1];
        end
    end

    msalu_merge u_merge (
        .ctl    (ctl_reg[DEPTH-1]),
        .active (active),
        .cmp    (cmp),
        .words  (words),
        .rsp    (merged)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_reg <= merged;
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp_word  = rsp_reg;

    a_stall_only_on_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall == (rsp_valid && rsp_stall))
        else $error("cmd_stall not tied to a held result");

    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && vld_reg[DEPTH-1]) |=> rsp_valid)
        else $error("finished word lost before output");

    a_drop_only_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(rsp_valid) |-> $past(!rsp_stall))
        else $error("result dropped while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_word.bit_count <= 2'(LANES)))
        else $error("bit_count exceeds lane count");

endmodule

[rtl/msalu_lane.sv]
// ----------------------------------------------------------------------------
// msalu_lane: one 32-bit lane
// Compute the other ops combinationally, then carry them beside a pipelined
// restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module msalu_lane (
    input  logic                            clk,
    input  logic                            advance,
    input  logic                            en,
    input  logic [3:0]                      op,
    input  logic [msalu_pkg::LANE_W-1:0]    a,
    input  logic [msalu_pkg::LANE_W-1:0]    b,
    input  logic [msalu_pkg::LANE_W-1:0]    scalar,
    input  logic [msalu_pkg::LANE_W-1:0]    old,
    output logic [msalu_pkg::LANE_W-1:0]    word,
    output logic                            cmp
);

    localparam int W = msalu_pkg::LANE_W;
    localparam int N = msalu_pkg::DIV_STEPS;

    msalu_pkg::lane_stage_t stg_reg  [0:N];
    msalu_pkg::lane_stage_t stg_next [0:N];

    logic [W-1:0]   val;
    logic [2*W-1:0] prod;
    logic           arith;
    logic [W:0]     tmp   [0:N-1];
    logic [W:0]     diff  [0:N-1];

    assign prod = a * b;

    always_comb
    begin
        case (op)
            msalu_pkg::OP_SET:  val = scalar;
            msalu_pkg::OP_MOVE: val = a;
            msalu_pkg::OP_ADD:  val = a + b;
            msalu_pkg::OP_SUB:  val = a - b;
            msalu_pkg::OP_MUL:  val = prod[W-1:0];
            default:            val = a[W-1] ? (W'(0) - a) : a;
        endcase
        arith = (op <= msalu_pkg::OP_ABS) && (op != msalu_pkg::OP_DIV);

        stg_next[0].rem = '0;
        stg_next[0].dq  = a[W-1] ? (W'(0) - a) : a;
        stg_next[0].dvs = b[W-1] ? (W'(0) - b) : b;
        stg_next[0].neg = a[W-1] ^ b[W-1];
        stg_next[0].dz  = (b == '0);
        stg_next[0].div = en && (op == msalu_pkg::OP_DIV);
        stg_next[0].res = (en && arith) ? val : old;
        case (op)
            msalu_pkg::OP_GT: stg_next[0].cmp = $signed(a) > $signed(b);
            msalu_pkg::OP_LT: stg_next[0].cmp = $signed(a) < $signed(b);
            msalu_pkg::OP_EQ: stg_next[0].cmp = (a == b);
            default:          stg_next[0].cmp = 1'b0;
        endcase

        for (int k = 0; k < N; k++)
        begin
            tmp[k]  = {stg_reg[k].rem, stg_reg[k].dq[W-1]};
            diff[k] = tmp[k] - {1'b0, stg_reg[k].dvs};
            stg_next[k+1]     = stg_reg[k];
            stg_next[k+1].rem = (tmp[k] >= {1'b0, stg_reg[k].dvs}) ? diff[k][W-1:0]
                                                                   : tmp[k][W-1:0];
            stg_next[k+1].dq  = {stg_reg[k].dq[W-2:0],
                                 (tmp[k] >= {1'b0, stg_reg[k].dvs})};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k <= N; k++)
                stg_reg[k] <= stg_next[k];
        end
    end

    always_comb
    begin
        if (!stg_reg[N].div)
            word = stg_reg[N].res;
        else if (stg_reg[N].dz)
            word = '1;
        else if (stg_reg[N].neg)
            word = W'(0) - stg_reg[N].dq;
        else
            word = stg_reg[N].dq;
    end

    assign cmp = stg_reg[N].cmp;

endmodule

[rtl/msalu_merge.sv]
// ----------------------------------------------------------------------------
// msalu_merge: combine lane results
// Pack lane words and build the mask result and population count.
// ----------------------------------------------------------------------------
module msalu_merge (
    input  msalu_pkg::ctl_t                                 ctl,
    input  logic [msalu_pkg::MAX_LANES-1:0]                 active,
    input  logic [msalu_pkg::MAX_LANES-1:0]                 cmp,
    input  logic [msalu_pkg::MAX_LANES*msalu_pkg::LANE_W-1:0] words,
    output msalu_pkg::rsp_t                                 rsp
);

    logic [1:0] lm;

    assign lm = ctl.lane_mask & active;

    always_comb
    begin
        rsp.result_vec = words;
        rsp.bit_count  = '0;
        case (ctl.op) inside
            msalu_pkg::OP_GT, msalu_pkg::OP_LT, msalu_pkg::OP_EQ:
                rsp.result_mask = (lm & cmp) | (~lm & ctl.old_mask);
            msalu_pkg::OP_NOT:
                rsp.result_mask = (active & ~ctl.lane_mask) | (~active & ctl.old_mask);
            msalu_pkg::OP_OR:
                rsp.result_mask = (active & (ctl.lane_mask | ctl.old_mask))
                                | (~active & ctl.old_mask);
            msalu_pkg::OP_AND:
                rsp.result_mask = (active & ctl.lane_mask & ctl.old_mask)
                                | (~active & ctl.old_mask);
            msalu_pkg::OP_FIRST:
                rsp.result_mask = (active & ctl.first_ones) | (~active & ctl.old_mask);
            msalu_pkg::OP_COUNT:
            begin
                rsp.result_mask = ctl.old_mask;
                rsp.bit_count   = {lm[1] & lm[0], lm[1] ^ lm[0]};
            end
            default:
                rsp.result_mask = ctl.old_mask;
        endcase
    end

endmodule
